// File: rtl/top_k_heap_select_sort_assert.svh
// Assertion macros for the top-k heap selector checker.
// No dependencies; included by the checker file.
`ifndef TOP_K_HEAP_SELECT_SORT_ASSERT_SVH
`define TOP_K_HEAP_SELECT_SORT_ASSERT_SVH
// implication checked on every clock, held off in reset
`define TKH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TKH_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/tkh_pkg.sv
// Package for the top-k heap selector: types, constants and key compare.
// No dependencies.
`timescale 1ns / 1ps
package tkh_pkg;
    localparam int ENTRY_W = 88;
    localparam int KEEP_W = 5;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd12;
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_UP_RD, ST_UP_CMP, ST_DN_RD, ST_DN_RD2, ST_DN_CMP,
        ST_SORT_RD, ST_SORT_SWP, ST_EMIT_RD, ST_EMIT_OUT
    } state_t;

    // entry layout: id [15:0], height [23:16], name [87:24]
    typedef struct packed {
        logic [63:0] name;
        logic [7:0]  height;
        logic [15:0] id;
    } entry_t;

    // a strictly greater than b
    function automatic logic key_gt(entry_t a, entry_t b, logic [63:0] mask);
        if (a.height != b.height) return a.height > b.height;
        return (a.name & mask) > (b.name & mask);
    endfunction
endpackage

// File: rtl/tkh_ram.sv
// Heap entry store: one synchronous memory, two read ports, one write port.
// Depends on tkh_pkg.
`timescale 1ns / 1ps
module tkh_ram import tkh_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output entry_t        rdata_a,
    output entry_t        rdata_b
);
    entry_t mem [DEPTH];

    // write and registered reads
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// File: rtl/top_k_heap_select_sort.sv
// Top level of the top-k heap selector: sequencer around the heap memory.
// Depends on tkh_pkg and tkh_ram.
`timescale 1ns / 1ps
// channel   dir  beat
// s_axis    in   tdata {record_id, name_key, height}, tuser = cmd
// m_axis    out  tdata {out_name_key, out_height, out_id}, tuser = empty_res, tlast = last
// cfg       in   keep_count write
// An insert that appends climbs one level per ST_UP_RD, ST_UP_CMP pair; a
// replacement does the root check in ST_DN_RD, then sifts down one level per
// ST_DN_RD2, ST_DN_CMP pair.
// A flush heapsorts in place (n-1 root swaps, each with a sift-down) and then
// streams min(n, k) beats through ST_EMIT_RD and ST_EMIT_OUT while m_tready holds.
// Reset is synchronous and active low; the heap needs no clearing pass.
// A stalled result beat holds the sequencer; no new item is taken meanwhile.
module top_k_heap_select_sort import tkh_pkg::*; #(
    parameter int MAX_K = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // height[7:0], name_key[71:8], record_id[87:72]
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // out_id[15:0], out_height[23:16], out_name_key[87:24]
    output logic         m_tuser,   // empty_res
    output logic         m_tlast,   // last
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data   // keep_count
);
    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1) + 1;
    localparam logic [63:0] NAME_MASK = ~64'd0 << (8 * (8 - NAME_BYTES));

    state_t state_reg, state_next;
    logic [KEEP_W-1:0] keep_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] size_reg, size_next;   // sift bound
    logic [CW-1:0] pos_reg, pos_next;     // 1-based hole index
    logic [CW-1:0] cnt_reg, cnt_next;     // emit counter
    logic [CW-1:0] num_reg, num_next;     // emit total
    logic          sorting_reg, sorting_next;
    entry_t cur_reg, cur_next;            // record being sifted
    logic [87:0] out_reg, out_next;
    logic out_empty_reg, out_empty_next;
    logic out_last_reg, out_last_next, out_v_reg, out_v_next;

    logic we;
    logic [AW-1:0] waddr, ra, rb;
    entry_t wdata, rda, rdb, inr, chd;
    logic [CW-1:0] keff, ra_n, rb_n, c_idx, ch_idx;
    logic s_fire, pick_r, dn_swap, up_swap, root_gt, last_beat;
    state_t done_st;

    tkh_ram #(.DEPTH(MAX_K), .AW(AW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
    );

    // effective k
    always_comb begin
        keff = CW'(keep_reg);
        if (keep_reg == '0) keff = CW'(1);
        if (CW'(keep_reg) > CW'(MAX_K)) keff = CW'(MAX_K);
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_v_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_v_reg;
    assign m_tdata = out_reg;
    assign m_tuser = out_empty_reg;
    assign m_tlast = out_last_reg;
    assign ra = AW'(ra_n - CW'(1));
    assign rb = AW'(rb_n - CW'(1));

    // shared compares: children of the hole, parent of the climber, root check
    assign s_fire = s_tvalid && s_tready;
    assign inr = '{name: s_tdata[71:8], height: s_tdata[7:0], id: s_tdata[87:72]};
    assign c_idx = pos_reg << 1;
    assign pick_r = ((c_idx + CW'(1)) <= size_reg) && key_gt(rdb, rda, NAME_MASK);
    assign ch_idx = pick_r ? c_idx + CW'(1) : c_idx;
    assign chd = pick_r ? rdb : rda;
    assign dn_swap = key_gt(chd, cur_reg, NAME_MASK);
    assign up_swap = key_gt(cur_reg, rda, NAME_MASK);
    assign root_gt = key_gt(rda, cur_reg, NAME_MASK);
    assign last_beat = (cnt_reg + CW'(1)) == num_reg;
    assign done_st = !sorting_reg ? ST_IDLE :
                     (size_reg > CW'(1)) ? ST_SORT_RD : ST_EMIT_RD;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == CMD_FLUSH) begin
                        if (fill_reg > CW'(1)) state_next = ST_SORT_RD;
                        else if (fill_reg == CW'(1)) state_next = ST_EMIT_RD;
                    end else if (fill_reg < keff) state_next = ST_UP_RD;
                    else state_next = ST_DN_RD;
                end
            end
            ST_UP_RD: state_next = (pos_reg == CW'(1)) ? ST_IDLE : ST_UP_CMP;
            ST_UP_CMP: state_next = up_swap ? ST_UP_RD : ST_IDLE;
            ST_DN_RD: state_next = root_gt ? ST_DN_RD2 : ST_IDLE;
            ST_DN_RD2: state_next = (c_idx > size_reg) ? done_st : ST_DN_CMP;
            ST_DN_CMP: state_next = dn_swap ? ST_DN_RD2 : done_st;
            ST_SORT_RD: state_next = ST_SORT_SWP;
            ST_SORT_SWP: state_next = ST_DN_RD2;
            ST_EMIT_RD: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (!out_v_reg || m_tready) state_next = last_beat ? ST_IDLE : ST_EMIT_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        fill_next = fill_reg; size_next = size_reg; pos_next = pos_reg;
        cnt_next = cnt_reg; num_next = num_reg; sorting_next = sorting_reg;
        cur_next = cur_reg; out_next = out_reg; out_empty_next = out_empty_reg;
        out_last_next = out_last_reg;
        out_v_next = out_v_reg && !m_tready;
        we = 1'b0; waddr = AW'(pos_reg - CW'(1)); wdata = cur_reg;
        ra_n = CW'(1); rb_n = CW'(1);
        unique case (state_reg)
            ST_IDLE: begin
                // root is read every idle cycle for the replacement check
                if (s_fire) begin
                    cur_next = inr;
                    if (s_tuser == CMD_FLUSH) begin
                        cnt_next = '0;
                        num_next = (fill_reg < keff) ? fill_reg : keff;
                        size_next = fill_reg;
                        sorting_next = 1'b1;
                        if (fill_reg == '0) begin
                            out_next = '0; out_empty_next = 1'b1;
                            out_last_next = 1'b1; out_v_next = 1'b1;
                        end
                    end else if (fill_reg < keff) begin
                        fill_next = fill_reg + CW'(1);
                        pos_next = fill_reg + CW'(1);
                    end else begin
                        size_next = fill_reg; pos_next = CW'(1); sorting_next = 1'b0;
                    end
                end
            end
            ST_UP_RD: begin
                // at the root the climber lands; otherwise fetch its parent
                ra_n = pos_reg >> 1;
                if (pos_reg == CW'(1)) we = 1'b1;
            end
            ST_UP_CMP: begin
                // parent moves down into the hole, or the climber lands
                we = 1'b1;
                if (up_swap) begin
                    wdata = rda; pos_next = pos_reg >> 1;
                end
            end
            ST_DN_RD: begin
            end
            ST_DN_RD2: begin
                // leaf hole takes the record; otherwise fetch both children
                ra_n = c_idx; rb_n = c_idx + CW'(1);
                if (c_idx > size_reg) we = 1'b1;
            end
            ST_DN_CMP: begin
                // larger child moves up into the hole, or the record lands
                we = 1'b1;
                if (dn_swap) begin
                    wdata = chd; pos_next = ch_idx;
                end
            end
            ST_SORT_RD: begin
                ra_n = CW'(1); rb_n = size_reg;
            end
            ST_SORT_SWP: begin
                // root to slot size, last element sifts from root
                we = 1'b1; waddr = AW'(size_reg - CW'(1)); wdata = rda;
                cur_next = rdb; size_next = size_reg - CW'(1); pos_next = CW'(1);
            end
            ST_EMIT_RD: ra_n = cnt_reg + CW'(1);
            ST_EMIT_OUT: begin
                ra_n = cnt_reg + CW'(1);
                if (!out_v_reg || m_tready) begin
                    out_next = {rda.name, rda.height, rda.id};
                    out_empty_next = 1'b0;
                    out_last_next = last_beat;
                    out_v_next = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    if (last_beat) fill_next = '0;
                end
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; keep_reg <= KEEP_RESET; fill_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next; fill_reg <= fill_next;
            out_v_reg <= out_v_next;
            if (cfg_valid && cfg_ready) keep_reg <= cfg_data;
        end
        size_reg <= size_next; pos_reg <= pos_next; cnt_reg <= cnt_next;
        num_reg <= num_next; sorting_reg <= sorting_next; cur_reg <= cur_next;
        out_reg <= out_next; out_empty_reg <= out_empty_next;
        out_last_reg <= out_last_next;
    end
endmodule

// File: rtl/tkh_checker.sv
// Port-level checker for the top-k heap selector, bound to the top level.
// Depends on top_k_heap_select_sort_assert.svh.
`timescale 1ns / 1ps
`include "top_k_heap_select_sort_assert.svh"
module tkh_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast,
    input logic m_tuser,
    input logic [87:0] m_tdata
);
    logic [89:0] m_beat;
    assign m_beat = {m_tuser, m_tlast, m_tdata};

    // a stalled result beat holds
    `TKH_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_beat))
    // no input taken while a result waits
    `TKH_ASSERT_IMP(a_excl, aclk, aresetn, m_tvalid, !s_tready)
    // an empty result is always the last of its flush
    `TKH_ASSERT_IMP(a_empty, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
endmodule

bind top_k_heap_select_sort tkh_checker u_tkh_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .m_tuser(m_tuser),
    .m_tdata(m_tdata)
);
